[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/ttbm_pkg.sv]
// ----------------------------------------------------------------------------
// ttbm_pkg
// Constants and types shared by the two-tone beep mixer and its sine lanes.
// ----------------------------------------------------------------------------
package ttbm_pkg;

    localparam int SAMPLE_RATE_DEF = 44100;
    localparam int LOW_TONE_HZ     = 547;
    localparam int HIGH_TONE_HZ    = 1823;
    localparam int TONE_PEAK       = 32767;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam logic [30:0] SC1  = 31'd1686629713;
    localparam logic [30:0] SC3  = 31'd693598668;
    localparam logic [30:0] SC5  = 31'd85569306;
    localparam logic [30:0] SC7  = 31'd5026996;
    localparam logic [30:0] SC9  = 31'd172272;
    localparam logic [30:0] SC11 = 31'd3864;

    localparam int SIN_LAT = 12;

    typedef logic [SIN_LAT-1:0] t_stage_en;

endpackage

[design/ttbm_sine.sv]
// ----------------------------------------------------------------------------
// ttbm_sine
// Pipelined Q1.14 sine of phase/SAMPLE_RATE cycles: quadrant fold, divide by
// the sample rate through a reciprocal with correction, Horner polynomial.
// ----------------------------------------------------------------------------
module ttbm_sine #(
    parameter int SAMPLE_RATE = ttbm_pkg::SAMPLE_RATE_DEF
) (
    input  logic                i_clk,
    input  ttbm_pkg::t_stage_en i_en,
    input  logic [15:0]         i_phase,
    output logic [14:0]         o_mag,
    output logic                o_neg
);
    import ttbm_pkg::*;

    localparam logic [17:0] LP_SR1 = 18'(SAMPLE_RATE);
    localparam logic [17:0] LP_SR2 = 18'(2 * SAMPLE_RATE);
    localparam logic [17:0] LP_SR3 = 18'(3 * SAMPLE_RATE);
    localparam logic [17:0] LP_SR4 = 18'(4 * SAMPLE_RATE);
    localparam logic [16:0] LP_SRR = 17'(SAMPLE_RATE);
    localparam logic [31:0] LP_SRM = 32'(SAMPLE_RATE);
    localparam logic [17:0] LP_Q   = 18'((2 ** 30) / SAMPLE_RATE);
    localparam logic [15:0] LP_R   = 16'((2 ** 30) % SAMPLE_RATE);
    localparam logic [27:0] LP_M   = 28'((64'd1 << 40) / SAMPLE_RATE);
    localparam int          NH     = 5;
    localparam logic [30:0] LP_COEF [NH] = '{SC9, SC7, SC5, SC3, SC1};

    function automatic logic [30:0] f_horner(input logic [30:0] c, input logic [30:0] s,
                                             input logic [30:0] x2);
        logic [61:0] p;
        p = 62'(s) * 62'(x2);
        return c - 31'(p >> 30);
    endfunction

    logic [17:0] w_q;
    logic [15:0] n_num;
    logic        n_neg;

    always_comb begin
        w_q = {i_phase, 2'b00};
        n_num = 16'(w_q);
        n_neg = 1'b0;
        priority if (w_q <= LP_SR1) begin
            n_num = 16'(w_q);
        end else if (w_q <= LP_SR2) begin
            n_num = 16'(LP_SR2 - w_q);
        end else if (w_q <= LP_SR3) begin
            n_num = 16'(w_q - LP_SR2);
            n_neg = 1'b1;
        end else begin
            n_num = 16'(LP_SR4 - w_q);
            n_neg = 1'b1;
        end
    end

    logic        r_neg [SIN_LAT];
    logic [15:0] r0_num;
    logic [31:0] r1_y;
    logic [30:0] r1_nq;
    logic [15:0] r2_t;
    logic [31:0] r2_y;
    logic [30:0] r2_nq;
    logic [15:0] r3_t;
    logic [16:0] r3_rem;
    logic [30:0] r3_nq;
    logic [30:0] r4_x;
    logic [30:0] r5_x;
    logic [30:0] r5_x2;
    logic [30:0] r_s  [NH];
    logic [30:0] r_hx [NH];
    logic [30:0] r_hx2[NH];
    logic [14:0] r11_mag;

    logic [33:0] w1_nq;
    logic [59:0] w2_p;
    logic [31:0] w3_tsr;
    logic [61:0] w5_sq;
    logic [61:0] w11_p;
    logic [32:0] w11_rnd;
    logic [16:0] w11_v;
    logic [30:0] w_s_in  [NH];
    logic [30:0] w_x_in  [NH];
    logic [30:0] w_x2_in [NH];

    always_comb begin
        w1_nq   = 34'(r0_num) * 34'(LP_Q);
        w2_p    = 60'(r1_y) * 60'(LP_M);
        w3_tsr  = 32'(r2_t) * LP_SRM;
        w5_sq   = 62'(r4_x) * 62'(r4_x);
        w11_p   = 62'(r_s[NH-1]) * 62'(r_hx[NH-1]);
        w11_rnd = 33'(w11_p[61:30]) + 33'd32768;
        w11_v   = w11_rnd[32:16];
        w_s_in[0]  = SC11;
        w_x_in[0]  = r5_x;
        w_x2_in[0] = r5_x2;
        for (int h = 1; h < NH; h++) begin
            w_s_in[h]  = r_s[h-1];
            w_x_in[h]  = r_hx[h-1];
            w_x2_in[h] = r_hx2[h-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_num   <= n_num;
            r_neg[0] <= n_neg;
        end
        for (int k = 1; k < SIN_LAT; k++) begin
            if (i_en[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
        if (i_en[1]) begin
            r1_y  <= 32'(r0_num) * 32'(LP_R);
            r1_nq <= w1_nq[30:0];
        end
        if (i_en[2]) begin
            r2_t  <= w2_p[55:40];
            r2_y  <= r1_y;
            r2_nq <= r1_nq;
        end
        if (i_en[3]) begin
            r3_t   <= r2_t;
            r3_rem <= 17'(r2_y - w3_tsr);
            r3_nq  <= r2_nq;
        end
        if (i_en[4]) begin
            r4_x <= r3_nq + 31'(r3_t) + 31'(r3_rem >= LP_SRR);
        end
        if (i_en[5]) begin
            r5_x  <= r4_x;
            r5_x2 <= w5_sq[60:30];
        end
        for (int h = 0; h < NH; h++) begin
            if (i_en[6+h]) begin
                r_s[h]   <= f_horner(LP_COEF[h], w_s_in[h], w_x2_in[h]);
                r_hx[h]  <= w_x_in[h];
                r_hx2[h] <= w_x2_in[h];
            end
        end
        if (i_en[SIN_LAT-1]) begin
            r11_mag <= (w11_v > 17'd16384) ? 15'd16384 : w11_v[14:0];
        end
    end

    assign o_mag = r11_mag;
    assign o_neg = r_neg[SIN_LAT-1];

endmodule

[design/two_tone_beep_mixer.sv]
// ----------------------------------------------------------------------------
// two_tone_beep_mixer
// Adds a 547 Hz plus 1823 Hz beep, each tone at half scale, to both channels
// of a stereo 16-bit frame stream while the tone gate in tuser is set, and
// clamps the sums to +/-32767; frames with the gate clear pass unchanged. The
// restart flag zeroes both tone phases before its frame. One frame is taken
// per clock cycle sustained while the receiver keeps up; each result passes
// through the 12-stage sine pipeline of each tone, whose first stage captures
// the frame at the transfer (reciprocal divide, then one multiplier per Horner
// step), and then the output register. Empty stages close up under
// backpressure, so frames keep entering while results wait.
// ----------------------------------------------------------------------------
module two_tone_beep_mixer #(
    parameter int SAMPLE_RATE = ttbm_pkg::SAMPLE_RATE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // left_in[15:0], right_in[31:16]
    input  logic [1:0]  i_s_axis_tuser,   // tone_on[0], tone_restart[1]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // left_out[15:0], right_out[31:16]
);
    import ttbm_pkg::*;

    localparam logic [16:0]        LP_SR      = 17'(SAMPLE_RATE);
    localparam logic [16:0]        LP_LO_STEP = 17'(LOW_TONE_HZ % SAMPLE_RATE);
    localparam logic [16:0]        LP_HI_STEP = 17'(HIGH_TONE_HZ % SAMPLE_RATE);
    localparam logic signed [17:0] LP_PEAK    = 18'(TONE_PEAK);

    function automatic logic [15:0] f_advance(input logic [15:0] p, input logic [16:0] step);
        logic [16:0] sum;
        sum = 17'(p) + step;
        if (sum >= LP_SR) begin
            sum = sum - LP_SR;
        end
        return sum[15:0];
    endfunction

    function automatic logic [15:0] f_mix(input logic [15:0] smp,
                                          input logic signed [16:0] tone);
        logic signed [17:0] sum;
        sum = 18'($signed(smp)) + 18'(tone);
        if (sum > LP_PEAK) begin
            sum = LP_PEAK;
        end
        if (sum < -LP_PEAK) begin
            sum = -LP_PEAK;
        end
        return sum[15:0];
    endfunction

    logic                r_out_vld;
    logic [15:0]         r_left_out;
    logic [15:0]         r_right_out;
    logic [SIN_LAT-1:0]  r_vld;
    logic [15:0]         r_left  [SIN_LAT];
    logic [15:0]         r_right [SIN_LAT];
    logic                r_on    [SIN_LAT];
    logic [15:0]         r_lo_phase;
    logic [15:0]         r_hi_phase;

    t_stage_en           w_en;
    logic                w_adv_out;
    logic                w_accept;
    logic                w_on;
    logic                w_restart;
    logic [15:0]         w_lo_cur;
    logic [15:0]         w_hi_cur;
    logic [14:0]         w_lo_mag;
    logic [14:0]         w_hi_mag;
    logic                w_lo_neg;
    logic                w_hi_neg;
    logic signed [16:0]  w_lo_tone;
    logic signed [16:0]  w_hi_tone;
    logic signed [16:0]  w_tone;
    logic [15:0]         n_left_out;
    logic [15:0]         n_right_out;

    assign w_adv_out = !r_out_vld || i_m_axis_tready;

    for (genvar k = 0; k < SIN_LAT; k++) begin : g_en
        assign w_en[k] = w_adv_out || !(&r_vld[SIN_LAT-1:k]);
    end

    assign o_s_axis_tready = w_en[0];
    assign w_accept        = i_s_axis_tvalid && w_en[0];
    assign w_on            = i_s_axis_tuser[0];
    assign w_restart       = i_s_axis_tuser[1];
    assign w_lo_cur        = w_restart ? 16'd0 : r_lo_phase;
    assign w_hi_cur        = w_restart ? 16'd0 : r_hi_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_phase <= 16'd0;
            r_hi_phase <= 16'd0;
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_on) begin
                    r_lo_phase <= f_advance(w_lo_cur, LP_LO_STEP);
                    r_hi_phase <= f_advance(w_hi_cur, LP_HI_STEP);
                end else if (w_restart) begin
                    r_lo_phase <= 16'd0;
                    r_hi_phase <= 16'd0;
                end
            end
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < SIN_LAT; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_adv_out) begin
                r_out_vld <= r_vld[SIN_LAT-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_left[0]  <= i_s_axis_tdata[15:0];
            r_right[0] <= i_s_axis_tdata[31:16];
            r_on[0]    <= w_on;
        end
        for (int k = 1; k < SIN_LAT; k++) begin
            if (w_en[k]) begin
                r_left[k]  <= r_left[k-1];
                r_right[k] <= r_right[k-1];
                r_on[k]    <= r_on[k-1];
            end
        end
        if (w_adv_out) begin
            r_left_out  <= n_left_out;
            r_right_out <= n_right_out;
        end
    end

    ttbm_sine #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_lo_sine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_lo_cur),
        .o_mag   (w_lo_mag),
        .o_neg   (w_lo_neg)
    );

    ttbm_sine #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_hi_sine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_hi_cur),
        .o_mag   (w_hi_mag),
        .o_neg   (w_hi_neg)
    );

    always_comb begin
        w_lo_tone = w_lo_neg ? -$signed({2'b00, w_lo_mag}) : $signed({2'b00, w_lo_mag});
        w_hi_tone = w_hi_neg ? -$signed({2'b00, w_hi_mag}) : $signed({2'b00, w_hi_mag});
        w_tone    = w_lo_tone + w_hi_tone;
        if (r_on[SIN_LAT-1]) begin
            n_left_out  = f_mix(r_left[SIN_LAT-1], w_tone);
            n_right_out = f_mix(r_right[SIN_LAT-1], w_tone);
        end else begin
            n_left_out  = r_left[SIN_LAT-1];
            n_right_out = r_right[SIN_LAT-1];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_right_out, r_left_out};

endmodule

[design/ttbm_checker.sv]
// ----------------------------------------------------------------------------
// ttbm_checker
// Port-level checks of the two-tone beep mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))
    `ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !o_m_axis_tvalid)
    `ASSERT_IMPL(a_ready_when_out_free, i_clk, i_rst_n, !o_m_axis_tvalid || i_m_axis_tready, o_s_axis_tready)

endmodule

bind two_tone_beep_mixer ttbm_checker u_ttbm_checker (.*);

[dv/tb_two_tone_beep_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_tone_beep_mixer
// Self-checking bench for the two-tone beep mixer. Stereo frames go in over
// the slave stream in bursts with random gaps. An in-bench model of the two
// phase accumulators and the Q1.14 quarter-wave sine predicts every output
// frame. Results are taken under a stalling receiver and compared field by
// field, in order. Directed frames cover the sample rails, gate and restart
// combinations and clamping. Random beeps of varied length follow, ending
// with flag noise.
// ----------------------------------------------------------------------------
module tb_two_tone_beep_mixer;

    import ttbm_pkg::*;

    localparam int RATE       = SAMPLE_RATE_DEF;
    localparam int SETTLE     = 40;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int PRINT_MAX  = 50;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } stereo_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // left_in[15:0], right_in[31:16]
    logic [1:0]  i_s_axis_tuser = '0;   // tone_on[0], tone_restart[1]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // left_out[15:0], right_out[31:16]

    stereo_t     expected_mix_q[$];
    int unsigned low_phase = 0;
    int unsigned high_phase = 0;
    int          mismatch_count = 0;
    int          burst_left = 0;

    two_tone_beep_mixer #(
        .SAMPLE_RATE(RATE)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // sin(pi/2 * x), x in Q30, result in Q14
    function automatic int quarter_sine(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] v;
        x2 = (x * x) >> 30;
        s  = 64'(SC11);
        s  = 64'(SC9) - ((s * x2) >> 30);
        s  = 64'(SC7) - ((s * x2) >> 30);
        s  = 64'(SC5) - ((s * x2) >> 30);
        s  = 64'(SC3) - ((s * x2) >> 30);
        s  = 64'(SC1) - ((s * x2) >> 30);
        v  = (s * x) >> 30;
        v  = (v + 64'd32768) >> 16;
        if (v > 64'd16384) begin
            v = 64'd16384;
        end
        return int'(v);
    endfunction

    function automatic int tone_sine(int unsigned phase);
        logic [63:0] rate;
        logic [63:0] quad;
        logic [63:0] num;
        logic        neg;
        int          mag;
        rate = 64'(RATE);
        quad = 64'(phase % RATE) * 64'd4;
        neg  = 1'b0;
        if (quad <= rate) begin
            num = quad;
        end else if (quad <= 2 * rate) begin
            num = 2 * rate - quad;
        end else if (quad <= 3 * rate) begin
            num = quad - 2 * rate;
            neg = 1'b1;
        end else begin
            num = 4 * rate - quad;
            neg = 1'b1;
        end
        mag = quarter_sine((num << 30) / rate);
        return neg ? -mag : mag;
    endfunction

    function automatic int unsigned step_phase(int unsigned p, int unsigned step);
        int unsigned n;
        n = (p % RATE) + (step % RATE);
        if (n >= RATE) begin
            n = n - RATE;
        end
        return n;
    endfunction

    function automatic logic [15:0] clamp_sum(int s, int tone);
        int v;
        v = s + tone;
        if (v > TONE_PEAK) begin
            v = TONE_PEAK;
        end
        if (v < -TONE_PEAK) begin
            v = -TONE_PEAK;
        end
        return 16'(v);
    endfunction

    function automatic stereo_t mix_frame(logic [15:0] left, logic [15:0] right,
                                          logic on, logic restart);
        stereo_t res;
        int      tone;
        res.left  = left;
        res.right = right;
        if (restart) begin
            low_phase  = 0;
            high_phase = 0;
        end
        if (on) begin
            tone       = tone_sine(low_phase) + tone_sine(high_phase);
            res.left   = clamp_sum($signed(left), tone);
            res.right  = clamp_sum($signed(right), tone);
            low_phase  = step_phase(low_phase, LOW_TONE_HZ);
            high_phase = step_phase(high_phase, HIGH_TONE_HZ);
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom % 8)
            0: return 16'(32767 - $urandom_range(0, 300));
            1: return 16'h8000 + 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (mismatch_count < PRINT_MAX) begin
            $display("ERROR %0t: %s got %0d expected %0d",
                     $realtime, what, $signed(got), $signed(want));
        end
        mismatch_count++;
    endtask

    task automatic send_frame(logic [15:0] left, logic [15:0] right,
                              logic on, logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom % 16 == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom % 8 == 0) ? $urandom_range(60, 150)
                                             : $urandom_range(1, 30);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {right, left};
        i_s_axis_tuser  <= {restart, on};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_mix_q.push_back(mix_frame(left, right, on, restart));
        burst_left--;
    endtask

    // hold the sender until every outstanding frame has come back
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic test_passthrough_extremes();
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b0, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_frame(16'h5555, 16'hAAAA, 1'b0, 1'b0);
        send_frame(16'hAAAA, 16'h5555, 1'b0, 1'b0);
    endtask

    task automatic test_gate_and_clamp();
        // zero tone at phase zero still pulls the negative rail in
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b1);
        for (int k = 0; k < 8; k++) begin
            if (k % 2 == 0) begin
                send_frame(16'h7FFF, 16'h8000, 1'b1, 1'b0);
            end else begin
                send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic test_restart_cases();
        send_frame(16'd100, -16'sd100, 1'b1, 1'b0);
        send_frame(16'd100, -16'sd100, 1'b1, 1'b0);
        send_frame(16'd0, 16'd0, 1'b0, 1'b1);
        send_frame(16'd1000, -16'sd1000, 1'b1, 1'b0);
        send_frame(16'd12345, -16'sd12345, 1'b1, 1'b1);
        send_frame(16'd7, 16'd7, 1'b0, 1'b0);
        send_frame(16'd7, 16'd7, 1'b1, 1'b0);
    endtask

    task automatic test_random_beeps(int n_frames);
        int sent;
        int run;
        sent = 0;
        while (sent < n_frames) begin
            run = ($urandom % 7 == 0) ? $urandom_range(100, 300) : $urandom_range(1, 60);
            for (int k = 0; k < run; k++) begin
                send_frame(pick_sample(), pick_sample(), 1'b1,
                           (k == 0) && ($urandom % 10 != 0));
            end
            sent += run;
            run = $urandom_range(0, 20);
            for (int k = 0; k < run; k++) begin
                send_frame(pick_sample(), pick_sample(), 1'b0, $urandom % 8 == 0);
            end
            sent += run;
        end
    endtask

    task automatic test_random_flags(int n_frames);
        for (int k = 0; k < n_frames; k++) begin
            send_frame(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // receiver: stall in segments of differing character
    initial begin : drive_ready
        int mode;
        int seg_left;
        int tick;
        seg_left = 0;
        tick     = 0;
        mode     = 0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = $urandom % 4;
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            tick++;
            case (mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom % 4 != 0);
                2: i_m_axis_tready <= ($urandom % 4 == 0);
                default: i_m_axis_tready <= (tick % 8) < 5;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        stereo_t got;
        stereo_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_mix_q.size() == 0) begin
                report_mismatch("unexpected transfer, left", got.left, 16'd0);
            end else begin
                want = expected_mix_q.pop_front();
                if (got.left !== want.left) begin
                    report_mismatch("left_out", got.left, want.left);
                end
                if (got.right !== want.right) begin
                    report_mismatch("right_out", got.right, want.right);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough_extremes();
        test_gate_and_clamp();
        test_restart_cases();
        wait_for_results();
        test_random_beeps(900);
        wait_for_results();
        test_random_flags(130);
        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_mix_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
